// ===== sv/qem_pkg.sv =====
// Types, constants and side tables shared by the quad edge matcher.
package qem_pkg;

	localparam int NODE_W = 16;
	localparam int ID_W   = 13;
	localparam int EL_W   = 12;

	// Command codes of an input transfer
	localparam logic CMD_ELEMENT = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	typedef struct packed {
		logic              command;
		logic [NODE_W-1:0] corner0;
		logic [NODE_W-1:0] corner1;
		logic [NODE_W-1:0] corner2;
		logic [NODE_W-1:0] corner3;
	} item_t;

	typedef struct packed {
		logic [1:0]        side;
		logic [ID_W-1:0]   edge_id;
		logic              is_new;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic              same_direction;
		logic [EL_W-1:0]   owner_element;
		logic [1:0]        owner_side;
		logic              error;
		logic              last;
	} result_t;

	// First owner record: element, side, start node
	typedef struct packed {
		logic [EL_W-1:0]   element;
		logic [1:0]        side;
		logic [NODE_W-1:0] start;
	} owner_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_OUT
	} state_t;

	// Corner index at the start and at the end of each side
	function automatic logic [1:0] side_start(input logic [1:0] s);
		unique case (s)
			2'd0: side_start = 2'd0;
			2'd1: side_start = 2'd1;
			2'd2: side_start = 2'd3;
			default: side_start = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] side_end(input logic [1:0] s);
		unique case (s)
			2'd0: side_end = 2'd1;
			2'd1: side_end = 2'd2;
			2'd2: side_end = 2'd2;
			default: side_end = 2'd3;
		endcase
	endfunction

endpackage

// ===== sv/quad_edge_matcher.sv =====
// Quad mesh edge matcher: top level with edge tables, scan sequencer and result register.

// Each element transfer yields four results, one per side, in side order. A side
// is resolved by a linear scan of the edge key memory, one stored edge per cycle
// through a single comparator, until a hit or the end of the table; item_stall
// drops only after the fourth result is taken. A clear transfer gives no result.
// An element past MAX_ELEMENTS gives four error results without a scan.
module quad_edge_matcher #(
	parameter int MAX_EDGES    = 8192,
	parameter int MAX_ELEMENTS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  qem_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output qem_pkg::result_t result
);
	import qem_pkg::*;

	localparam int IW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam int ECW = $clog2(MAX_ELEMENTS + 1);

	// Edge tables
	logic [2*NODE_W-1:0] key_mem [MAX_EDGES];
	owner_t              own_mem [MAX_EDGES];

	state_t              state_q, state_d;
	logic [NODE_W-1:0]   c_q [4];
	logic [1:0]          side_q;
	logic [ECW-1:0]      elem_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       scan_q;
	logic                rdv_q;
	logic [2*NODE_W-1:0] rdkey_q;
	logic [IW-1:0]       rdidx_q;
	owner_t              fo_q;
	logic                ovf_q;
	result_t             res_q;

	logic [NODE_W-1:0]   node_a, node_b, lo, hi;
	logic [2*NODE_W-1:0] key;
	logic                hit, miss, more, full, item_xfer, res_xfer;
	logic                key_we;

	// Current side's oriented pair and unordered key
	always_comb begin
		node_a = c_q[side_start(side_q)];
		node_b = c_q[side_end(side_q)];
		lo     = (node_a < node_b) ? node_a : node_b;
		hi     = (node_a < node_b) ? node_b : node_a;
		key    = {hi, lo};
	end

	assign item_xfer    = item_valid && (state_q == ST_IDLE);
	assign res_xfer     = (state_q == ST_OUT) && !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_OUT);
	assign result       = res_q;

	assign hit    = rdv_q && (rdkey_q == key);
	assign more   = (scan_q < count_q);
	assign miss   = !rdv_q && !more;
	assign full   = (count_q == CW'(MAX_EDGES));
	assign key_we = (state_q == ST_SCAN) && miss && !full;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_xfer && item.command == CMD_ELEMENT) begin
					state_d = (elem_q >= ECW'(MAX_ELEMENTS)) ? ST_OUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_FETCH;
				end else if (miss) begin
					state_d = ST_OUT;
				end
			end
			ST_FETCH: state_d = ST_OUT;
			ST_OUT: begin
				if (res_xfer) begin
					if (side_q == 2'd3) begin
						state_d = ST_IDLE;
					end else if (!ovf_q) begin
						state_d = ST_SCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the corners of an accepted element
	always_ff @(posedge clk) begin
		if (item_xfer && item.command == CMD_ELEMENT) begin
			c_q[0] <= item.corner0;
			c_q[1] <= item.corner1;
			c_q[2] <= item.corner2;
			c_q[3] <= item.corner3;
		end
	end

	// Key memory: one read port for the scan, one write port for allocation
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[count_q[IW-1:0]] <= key;
		end
		rdkey_q <= key_mem[scan_q[IW-1:0]];
	end

	// Owner memory: read at the matched index
	always_ff @(posedge clk) begin
		if (key_we) begin
			own_mem[count_q[IW-1:0]] <= '{element: EL_W'(elem_q - ECW'(1)),
				side: side_q, start: node_a};
		end
		fo_q <= own_mem[rdidx_q];
	end

	// Sequencer control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= '0;
			elem_q  <= '0;
			count_q <= '0;
			scan_q  <= '0;
			rdv_q   <= 1'b0;
			rdidx_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					side_q <= '0;
					scan_q <= '0;
					rdv_q  <= 1'b0;
					if (item_xfer) begin
						if (item.command == CMD_CLEAR) begin
							elem_q  <= '0;
							count_q <= '0;
						end else if (elem_q >= ECW'(MAX_ELEMENTS)) begin
							ovf_q <= 1'b1;
						end else begin
							ovf_q  <= 1'b0;
							elem_q <= elem_q + ECW'(1);
						end
					end
				end
				ST_SCAN: begin
					// advance the scan one entry per cycle until hit or end of table
					if (!hit && !miss) begin
						rdv_q <= more;
						if (more) begin
							rdidx_q <= scan_q[IW-1:0];
							scan_q  <= scan_q + CW'(1);
						end
					end
					if (key_we) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_FETCH: begin
				end
				ST_OUT: begin
					if (res_xfer && side_q != 2'd3) begin
						side_q <= side_q + 2'd1;
						scan_q <= '0;
						rdv_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_q       <= '0;
				res_q.error <= 1'b1;
			end
			ST_SCAN: begin
				if (miss) begin
					res_q      <= '0;
					res_q.side <= side_q;
					res_q.last <= (side_q == 2'd3);
					if (full) begin
						res_q.error <= 1'b1;
					end else begin
						res_q.edge_id        <= ID_W'(count_q);
						res_q.is_new         <= 1'b1;
						res_q.node_a         <= side_q[1] ? node_b : node_a;
						res_q.node_b         <= side_q[1] ? node_a : node_b;
						res_q.same_direction <= 1'b1;
						res_q.owner_element  <= EL_W'(elem_q - ECW'(1));
						res_q.owner_side     <= side_q;
					end
				end
			end
			ST_FETCH: begin
				res_q                <= '0;
				res_q.side           <= side_q;
				res_q.last           <= (side_q == 2'd3);
				res_q.edge_id        <= ID_W'(rdidx_q);
				res_q.same_direction <= (node_a == fo_q.start);
				res_q.owner_element  <= fo_q.element;
				res_q.owner_side     <= fo_q.side;
			end
			ST_OUT: begin
				// step the error results of an overflowed element
				if (res_xfer && ovf_q) begin
					res_q.side <= side_q + 2'd1;
					res_q.last <= (side_q == 2'd2);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
